// ----- rtl/qtue_pkg.sv -----
// Shared types and constants of the Q table update engine.
package qtue_pkg;

  localparam int ROW_COUNT    = 16;
  localparam int COL_COUNT    = 16;
  localparam int ACTION_COUNT = 4;

  localparam int ROW_W  = 4;
  localparam int COL_W  = 4;
  localparam int ACT_W  = $clog2(ACTION_COUNT);
  localparam int MASK_W = 4;
  localparam int ADDR_W = $clog2(ROW_COUNT * COL_COUNT);
  localparam int DEPTH  = ROW_COUNT * COL_COUNT;

  localparam int Q_W    = 32;
  localparam int FRAC_W = 16;
  localparam int CF_W   = 17;
  localparam int ROW_BITS = ACTION_COUNT * Q_W;

  localparam int P1_W   = Q_W + CF_W + 1;
  localparam int DIFF_W = Q_W + 3;
  localparam int P2_W   = DIFF_W + CF_W + 1;
  localparam int SUM_W  = P2_W - FRAC_W + 1;

  localparam logic [CF_W-1:0] ONE_Q16     = CF_W'(65536);
  localparam logic [CF_W-1:0] CF_RESET    = CF_W'(52429);
  localparam logic [ACT_W-1:0] LAST_ACT   = ACT_W'(ACTION_COUNT - 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  localparam logic CFG_LEARNING_RATE   = 1'b0;
  localparam logic CFG_DISCOUNT_FACTOR = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_GREEDY,
    S_SCAN,
    S_RD_OLD,
    S_DIFF,
    S_MUL,
    S_FIN
  } state_t;

  typedef struct packed {
    logic              load_in;
    logic              rd_en;
    logic              rd_old;
    logic              scan_en;
    logic [ACT_W-1:0]  scan_idx;
    logic              mul1_en;
    logic              diff_en;
    logic              mul2_en;
    logic              fin;
    logic              clr_en;
    logic [ADDR_W-1:0] clr_addr;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_query;
  } dp_status_t;

endpackage

// ----- rtl/q_table_update_engine.sv -----
// Top level of the tabular Q-learning update engine.
// Each request runs through a greedy row read, a four-step scan and, for updates,
// an old-value row read, two multiply steps and a write; a new request is taken only
// once the last one has passed its finish step and the engine is back in idle.
// Reset: synchronous, active low; a clearing pass then zeroes the table one row per
// cycle until all 256 rows are clear, during which no request is accepted.
module q_table_update_engine import qtue_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // Request channel.
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_kind,
  input  logic [ROW_W-1:0]      in_state_row,
  input  logic [COL_W-1:0]      in_state_col,
  input  logic [ACT_W-1:0]      in_taken_action,
  input  logic [ROW_W-1:0]      in_next_row,
  input  logic [COL_W-1:0]      in_next_col,
  input  logic signed [Q_W-1:0] in_reward_value,
  input  logic [MASK_W-1:0]     in_legal_mask,
  // Result channel.
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [Q_W-1:0] out_q_result,
  output logic [ACT_W-1:0]      out_best_action,
  output logic                  out_any_legal,
  // Configuration write port.
  input  logic                  cfg_wr_en,
  input  logic                  cfg_index,
  input  logic [CF_W-1:0]       cfg_wdata
);

  // The controller sequences each request; the datapath holds the table, the
  // latched request, the running maximum and the fixed-point arithmetic.
  ctrl_cmd_t  cmd;
  dp_status_t status;

  qtue_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // The output register lets a new request be accepted while a result waits;
  // the finish step of that request then holds until the result is taken.
  qtue_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_kind         (in_kind),
    .in_state_row    (in_state_row),
    .in_state_col    (in_state_col),
    .in_taken_action (in_taken_action),
    .in_next_row     (in_next_row),
    .in_next_col     (in_next_col),
    .in_reward_value (in_reward_value),
    .in_legal_mask   (in_legal_mask),
    .out_q_result    (out_q_result),
    .out_best_action (out_best_action),
    .out_any_legal   (out_any_legal)
  );

endmodule

// ----- rtl/qtue_ctrl.sv -----
// Sequencer of the Q table update engine: clearing pass, read, scan and finish steps.
module qtue_ctrl import qtue_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t            state_r, state_nxt;
  logic [ACT_W-1:0]  scan_cnt_r, scan_cnt_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              fin_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      scan_cnt_r  <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The finish step waits until the output register is free.
  assign fin_go = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt    = state_r;
    scan_cnt_nxt = scan_cnt_r;
    clr_cnt_nxt  = clr_cnt_r;
    cmd          = '0;
    cmd.scan_idx = scan_cnt_r;
    cmd.clr_addr = clr_cnt_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_en  = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_RD_GREEDY;
        end
      end
      S_RD_GREEDY: begin
        cmd.rd_en    = 1'b1;
        scan_cnt_nxt = '0;
        state_nxt    = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_en  = 1'b1;
        scan_cnt_nxt = scan_cnt_r + 1'b1;
        if (scan_cnt_r == LAST_ACT) begin
          state_nxt = status.is_query ? S_FIN : S_RD_OLD;
        end
      end
      S_RD_OLD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_old  = 1'b1;
        cmd.mul1_en = 1'b1;
        state_nxt   = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff_en = 1'b1;
        state_nxt   = S_MUL;
      end
      S_MUL: begin
        cmd.mul2_en = 1'b1;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (fin_go) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fin_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- rtl/qtue_datapath.sv -----
// Datapath of the Q table update engine: table memory, greedy scan, update arithmetic.
module qtue_datapath import qtue_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ctrl_cmd_t               cmd,
  output dp_status_t              status,
  input  logic                    cfg_wr_en,
  input  logic                    cfg_index,
  input  logic [CF_W-1:0]         cfg_wdata,
  input  logic                    in_kind,
  input  logic [ROW_W-1:0]        in_state_row,
  input  logic [COL_W-1:0]        in_state_col,
  input  logic [ACT_W-1:0]        in_taken_action,
  input  logic [ROW_W-1:0]        in_next_row,
  input  logic [COL_W-1:0]        in_next_col,
  input  logic signed [Q_W-1:0]   in_reward_value,
  input  logic [MASK_W-1:0]       in_legal_mask,
  output logic signed [Q_W-1:0]   out_q_result,
  output logic [ACT_W-1:0]        out_best_action,
  output logic                    out_any_legal
);

  logic [ROW_BITS-1:0] mem [DEPTH];
  logic [ROW_BITS-1:0] rdata_r;

  logic [CF_W-1:0]        alpha_r, gamma_r;
  logic [CF_W-1:0]        alpha_eff, gamma_eff;

  logic                   kind_r;
  logic [ROW_W-1:0]       srow_r, nrow_r;
  logic [COL_W-1:0]       scol_r, ncol_r;
  logic [ACT_W-1:0]       take_act_r;
  logic signed [Q_W-1:0]  reward_r;
  logic [MASK_W-1:0]      mask_r;

  logic signed [Q_W-1:0]  best_r;
  logic [ACT_W-1:0]       best_act_r;
  logic                   found_r;

  logic signed [P1_W-1:0]   prod1_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic signed [P2_W-1:0]   prod2_r;

  logic signed [Q_W-1:0]  out_q_r;
  logic [ACT_W-1:0]       out_act_r;
  logic                   out_any_r;

  logic [ADDR_W-1:0]      s_addr, n_addr, rd_addr, wr_addr;
  logic                   wr_en;
  logic [ROW_BITS-1:0]    wr_row;
  logic signed [Q_W-1:0]  lane_q, old_q, res_sat;
  logic signed [SUM_W-1:0] sum;
  logic                   take;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= CF_RESET;
      gamma_r <= CF_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_LEARNING_RATE:   alpha_r <= cfg_wdata;
        CFG_DISCOUNT_FACTOR: gamma_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign alpha_eff = (alpha_r > ONE_Q16) ? ONE_Q16 : alpha_r;
  assign gamma_eff = (gamma_r > ONE_Q16) ? ONE_Q16 : gamma_r;

  assign s_addr  = ADDR_W'(int'(srow_r) * COL_COUNT + int'(scol_r));
  assign n_addr  = ADDR_W'(int'(nrow_r) * COL_COUNT + int'(ncol_r));
  assign rd_addr = (cmd.rd_old || kind_r == KIND_QUERY) ? s_addr : n_addr;

  assign lane_q = rdata_r[cmd.scan_idx*Q_W +: Q_W];
  assign old_q  = rdata_r[take_act_r*Q_W +: Q_W];

  // First legal maximum wins: a later lane must be strictly greater.
  assign take = mask_r[cmd.scan_idx] && (!found_r || lane_q > best_r);

  // new = old + floor(alpha * (sample - old) / 2^16), then saturate.
  assign sum = SUM_W'(old_q) + SUM_W'(prod2_r >>> FRAC_W);

  always_comb begin
    if (sum[SUM_W-1] && !(&sum[SUM_W-2:Q_W-1])) begin
      res_sat = {1'b1, {(Q_W-1){1'b0}}};
    end else if (!sum[SUM_W-1] && (|sum[SUM_W-2:Q_W-1])) begin
      res_sat = {1'b0, {(Q_W-1){1'b1}}};
    end else begin
      res_sat = sum[Q_W-1:0];
    end
  end

  always_comb begin
    wr_row = rdata_r;
    wr_row[take_act_r*Q_W +: Q_W] = res_sat;
    if (cmd.clr_en) begin
      wr_row = '0;
    end
  end

  assign wr_en   = cmd.clr_en || (cmd.fin && kind_r == KIND_UPDATE);
  assign wr_addr = cmd.clr_en ? cmd.clr_addr : s_addr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r     <= in_kind;
      srow_r     <= in_state_row;
      scol_r     <= in_state_col;
      take_act_r <= in_taken_action;
      nrow_r     <= in_next_row;
      ncol_r     <= in_next_col;
      reward_r   <= in_reward_value;
      mask_r     <= in_legal_mask;
      best_r     <= '0;
      best_act_r <= '0;
      found_r    <= 1'b0;
    end else if (cmd.scan_en && take) begin
      best_r     <= lane_q;
      best_act_r <= cmd.scan_idx;
      found_r    <= 1'b1;
    end
    if (cmd.mul1_en) begin
      prod1_r <= $signed({1'b0, gamma_eff}) * best_r;
    end
    if (cmd.diff_en) begin
      diff_r <= DIFF_W'(reward_r) + DIFF_W'(prod1_r >>> FRAC_W) - DIFF_W'(old_q);
    end
    if (cmd.mul2_en) begin
      prod2_r <= $signed({1'b0, alpha_eff}) * diff_r;
    end
    if (cmd.fin) begin
      out_q_r   <= (kind_r == KIND_QUERY) ? best_r : res_sat;
      out_act_r <= best_act_r;
      out_any_r <= found_r;
    end
  end

  assign status.is_query = (kind_r == KIND_QUERY);
  assign out_q_result    = out_q_r;
  assign out_best_action = out_act_r;
  assign out_any_legal   = out_any_r;

endmodule
